// ===== rtl/core/wmsc_pkg.sv =====
// Shared constants and types for the window midpoint step counter.
`default_nettype none

package wmsc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SIM_W       = 7;
    localparam int RATIO_W     = 8;
    localparam int STEP_W      = 16;
    localparam int AXIS_W      = 2;

    localparam int S_FIELDS_W = 3 * SAMPLE_BITS + SIM_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STEP_W + 1 + 1 + AXIS_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int SWING_W = SAMPLE_BITS + 1;
    localparam int MID10_W = SAMPLE_BITS + 4;
    localparam int PROD_W  = SAMPLE_BITS + RATIO_W + 1;
    localparam int CMP_W   = (PROD_W > MID10_W) ? PROD_W + 1 : MID10_W + 1;

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic REG_SIM_MIN    = 1'b0;
    localparam logic REG_RISE_RATIO = 1'b1;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic [SIM_W-1:0]   SIM_MIN_RESET    = SIM_W'(90);
    localparam logic [RATIO_W-1:0] RISE_RATIO_RESET = RATIO_W'(11);
    localparam logic [STEP_W-1:0]  STEP_TOP         = {STEP_W{1'b1}};

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAXV = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MINV = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

endpackage

`default_nettype wire

// ===== rtl/core/window_midpoint_step_counter_top.sv =====
// Top level of the window midpoint step counter.
`default_nettype none

// Takes one accelerometer sample beat per cycle and keeps per-axis max/min
// over the current window. The beat with tlast closes the window: the
// similarity score decides walking, the first walking window picks the axis
// with the largest swing and stores its midpoint, later walking windows count
// a step when 10 * midpoint exceeds rise_ratio_tenths * previous midpoint.
// One result beat per window end. An input beat reaches the result beat
// through an input register, then the tracking/decision logic into the
// result register. Sustained rate is one sample per cycle; the only stall is
// a window end meeting a full, untaken result register.
module window_midpoint_step_counter_top
    import wmsc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // sample_x, sample_y, sample_z, similarity, zero pad
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    input  wire logic                s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // step_count, step_counted, walking, dominant_axis, zero pad
    output logic [M_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    // configuration
    logic [SIM_W-1:0]   sim_min_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sim_min_reg <= SIM_MIN_RESET;
            ratio_reg   <= RISE_RATIO_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_SIM_MIN:    sim_min_reg <= pwdata[SIM_W-1:0];
                REG_RISE_RATIO: ratio_reg   <= pwdata[RATIO_W-1:0];
                default:        sim_min_reg <= sim_min_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SIM_MIN:    prdata = PDATA_W'(sim_min_reg);
            REG_RISE_RATIO: prdata = PDATA_W'(ratio_reg);
            default:        prdata = '0;
        endcase
    end

    // input register
    logic             in_valid_reg;
    sample_t          x_reg, y_reg, z_reg;
    logic [SIM_W-1:0] sim_reg;
    logic             last_reg;
    logic             proc;
    logic             out_valid_reg;

    assign proc          = in_valid_reg && (!last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            x_reg    <= s_axis_tdata[SAMPLE_BITS-1:0];
            y_reg    <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            z_reg    <= s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
            sim_reg  <= s_axis_tdata[3*SAMPLE_BITS+SIM_W-1:3*SAMPLE_BITS];
            last_reg <= s_axis_tlast;
        end
    end

    // extremes including the current sample
    sample_t max_x_reg, min_x_reg, max_y_reg, min_y_reg, max_z_reg, min_z_reg;
    sample_t max_x_next, min_x_next, max_y_next, min_y_next, max_z_next, min_z_next;

    assign max_x_next = (x_reg > max_x_reg) ? x_reg : max_x_reg;
    assign min_x_next = (x_reg < min_x_reg) ? x_reg : min_x_reg;
    assign max_y_next = (y_reg > max_y_reg) ? y_reg : max_y_reg;
    assign min_y_next = (y_reg < min_y_reg) ? y_reg : min_y_reg;
    assign max_z_next = (z_reg > max_z_reg) ? z_reg : max_z_reg;
    assign min_z_next = (z_reg < min_z_reg) ? z_reg : min_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= SAMPLE_MINV;
            min_x_reg <= SAMPLE_MAXV;
            max_y_reg <= SAMPLE_MINV;
            min_y_reg <= SAMPLE_MAXV;
            max_z_reg <= SAMPLE_MINV;
            min_z_reg <= SAMPLE_MAXV;
        end
        else if (proc)
        begin
            if (last_reg)
            begin
                max_x_reg <= SAMPLE_MINV;
                min_x_reg <= SAMPLE_MAXV;
                max_y_reg <= SAMPLE_MINV;
                min_y_reg <= SAMPLE_MAXV;
                max_z_reg <= SAMPLE_MINV;
                min_z_reg <= SAMPLE_MAXV;
            end
            else
            begin
                max_x_reg <= max_x_next;
                min_x_reg <= min_x_next;
                max_y_reg <= max_y_next;
                min_y_reg <= min_y_next;
                max_z_reg <= max_z_next;
                min_z_reg <= min_z_next;
            end
        end
    end

    // window-end decision
    logic                      walking;
    logic signed [SWING_W-1:0] swing_x, swing_y, swing_z;
    logic [AXIS_W-1:0]         new_axis;
    logic [AXIS_W-1:0]         axis_sel;
    sample_t                   sel_max, sel_min;
    logic signed [SWING_W-1:0] mid_sum;
    sample_t                   mid;
    logic signed [MID10_W-1:0] mid10;
    logic signed [PROD_W-1:0]  prod;
    logic                      rise;

    logic [AXIS_W-1:0] axis_reg;
    sample_t           prev_mid_reg;
    logic              first_reg;
    logic [STEP_W-1:0] steps_reg;

    assign walking = sim_reg >= sim_min_reg;

    assign swing_x = SWING_W'(max_x_next) - SWING_W'(min_x_next);
    assign swing_y = SWING_W'(max_y_next) - SWING_W'(min_y_next);
    assign swing_z = SWING_W'(max_z_next) - SWING_W'(min_z_next);

    always_comb
    begin
        if (swing_x >= swing_y && swing_x >= swing_z)
            new_axis = AXIS_X;
        else if (swing_y >= swing_z)
            new_axis = AXIS_Y;
        else
            new_axis = AXIS_Z;
    end

    assign axis_sel = first_reg ? new_axis : axis_reg;

    always_comb
    begin
        case (axis_sel)
            AXIS_X:
            begin
                sel_max = max_x_next;
                sel_min = min_x_next;
            end
            AXIS_Y:
            begin
                sel_max = max_y_next;
                sel_min = min_y_next;
            end
            default:
            begin
                sel_max = max_z_next;
                sel_min = min_z_next;
            end
        endcase
    end

    // arithmetic shift of the sum floors toward minus infinity
    assign mid_sum = SWING_W'(sel_max) + SWING_W'(sel_min);
    assign mid     = mid_sum[SWING_W-1:1];
    assign mid10   = (MID10_W'(mid) <<< 3) + (MID10_W'(mid) <<< 1);
    assign prod    = prev_mid_reg * $signed({1'b0, ratio_reg});
    assign rise    = CMP_W'(mid10) > CMP_W'(prod);

    logic counted;
    assign counted = walking && !first_reg && rise;

    logic [STEP_W-1:0] steps_next;
    assign steps_next = (counted && steps_reg != STEP_TOP) ? steps_reg + STEP_W'(1) : steps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg     <= AXIS_X;
            prev_mid_reg <= '0;
            first_reg    <= 1'b1;
            steps_reg    <= '0;
        end
        else if (proc && last_reg)
        begin
            if (!walking)
                first_reg <= 1'b1;
            else
            begin
                first_reg    <= 1'b0;
                axis_reg     <= axis_sel;
                prev_mid_reg <= mid;
                steps_reg    <= steps_next;
            end
        end
    end

    // result register
    logic [STEP_W-1:0] res_steps_reg;
    logic              res_counted_reg;
    logic              res_walking_reg;
    logic [AXIS_W-1:0] res_axis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc && last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc && last_reg)
        begin
            res_steps_reg   <= walking ? steps_next : steps_reg;
            res_counted_reg <= counted;
            res_walking_reg <= walking;
            res_axis_reg    <= walking ? axis_sel : axis_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_DATA_W'({res_axis_reg, res_walking_reg, res_counted_reg,
                                      res_steps_reg});

endmodule

`default_nettype wire
